### design/dks_pkg.sv
// shared types, constants and permutation functions of the des key schedule
package dks_pkg;

    localparam int HalfBits   = 28;
    localparam int JoinedBits = 56;
    localparam int KeyBits    = 64;
    localparam int SubkeyBits = 48;
    localparam int RoundBits  = 4;

    localparam logic [RoundBits-1:0] FirstRound = 4'd0;
    localparam logic [RoundBits-1:0] LastRound  = 4'd15;

    typedef logic [HalfBits-1:0]   t_half;
    typedef logic [JoinedBits-1:0] t_joined;
    typedef logic [KeyBits-1:0]    t_key;
    typedef logic [SubkeyBits-1:0] t_subkey;
    typedef logic [RoundBits-1:0]  t_round;

    // queue occupancy seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    localparam logic [7:0] Pc1Table [JoinedBits] = '{
        8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,
        8'd1,  8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18,
        8'd10, 8'd2,  8'd59, 8'd51, 8'd43, 8'd35, 8'd27,
        8'd19, 8'd11, 8'd3,  8'd60, 8'd52, 8'd44, 8'd36,
        8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15,
        8'd7,  8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22,
        8'd14, 8'd6,  8'd61, 8'd53, 8'd45, 8'd37, 8'd29,
        8'd21, 8'd13, 8'd5,  8'd28, 8'd20, 8'd12, 8'd4
    };

    localparam logic [7:0] Pc2Table [SubkeyBits] = '{
        8'd14, 8'd17, 8'd11, 8'd24, 8'd1,  8'd5,
        8'd3,  8'd28, 8'd15, 8'd6,  8'd21, 8'd10,
        8'd23, 8'd19, 8'd12, 8'd4,  8'd26, 8'd8,
        8'd16, 8'd7,  8'd27, 8'd20, 8'd13, 8'd2,
        8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55,
        8'd30, 8'd40, 8'd51, 8'd45, 8'd33, 8'd48,
        8'd44, 8'd49, 8'd39, 8'd56, 8'd34, 8'd53,
        8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32
    };

    // bit r set where round r rotates by two instead of one
    localparam logic [15:0] ShiftTwoMask = 16'b0111_1110_1111_1100;

    // pc-1: table entry p picks key bit p counted from the msb, starting at 1
    function automatic t_joined pc1(input t_key key);
        t_joined sel;
        sel = '0;
        for (int i = 0; i < JoinedBits; i++) begin
            sel[JoinedBits-1-i] = key[KeyBits - int'(Pc1Table[i])];
        end
        return sel;
    endfunction

    function automatic t_subkey pc2(input t_joined cd);
        t_subkey sub;
        sub = '0;
        for (int i = 0; i < SubkeyBits; i++) begin
            sub[SubkeyBits-1-i] = cd[JoinedBits - int'(Pc2Table[i])];
        end
        return sub;
    endfunction

    function automatic t_half rot_half(input t_half x, input logic two);
        t_half y;
        if (two) begin
            y = {x[HalfBits-3:0], x[HalfBits-1:HalfBits-2]};
        end else begin
            y = {x[HalfBits-2:0], x[HalfBits-1]};
        end
        return y;
    endfunction

endpackage

### design/dks_front.sv
// input side: takes keys, applies pc-1 and pushes the c/d pair into the queue
module dks_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  dks_pkg::t_key          i_key_value,
    output logic                   o_stall,
    input  dks_pkg::t_q_stat       i_q_stat,
    output logic                   o_push,
    output dks_pkg::t_joined       o_push_data
);
    import dks_pkg::*;

    assign o_stall     = i_q_stat.full;
    assign o_push      = i_valid && !i_q_stat.full;
    assign o_push_data = pc1(i_key_value);

    // a push must never land on a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_stat.full)
        else $error("push into full queue");

    // every key transfer turns into exactly one push
    a_transfer_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |-> o_push)
        else $error("key transfer without push");

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_q_stat.full && i_q_stat.empty))
        else $error("queue both full and empty");

endmodule

### design/dks_queue.sv
// two-entry queue of pc-1 outputs between the front and the round engine
module dks_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  dks_pkg::t_joined       i_push_data,
    input  logic                   i_pop,
    output dks_pkg::t_joined       o_pop_data,
    output dks_pkg::t_q_stat       o_q_stat
);
    import dks_pkg::*;

    logic    r_wr_ptr;
    logic    r_rd_ptr;
    logic [1:0] r_count;
    logic    n_wr_ptr;
    logic    n_rd_ptr;
    logic [1:0] n_count;
    t_joined r_mem [2];

    always_comb begin
        n_wr_ptr = i_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop  ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_pop_data     = r_mem[r_rd_ptr];
    assign o_q_stat.full  = (r_count == 2'd2);
    assign o_q_stat.empty = (r_count == 2'd0);

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != 2'd0))
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

    // pointers agree with the count: equal only when empty or full
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) |-> (r_wr_ptr != r_rd_ptr))
        else $error("queue pointers out of step");

endmodule

### design/dks_back.sv
// round engine: rotates the halves once per cycle unless the output stalls, and registers each subkey
module dks_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  dks_pkg::t_q_stat       i_q_stat,
    input  dks_pkg::t_joined       i_pop_data,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_stall,
    output dks_pkg::t_subkey       o_round_key,
    output dks_pkg::t_round        o_round_number,
    output logic                   o_last_key
);
    import dks_pkg::*;

    logic    r_busy;
    t_round  r_round;
    t_half   r_c;
    t_half   r_d;
    logic    r_out_valid;
    t_subkey r_out_key;
    t_round  r_out_round;
    logic    r_out_last;

    logic    n_busy;
    t_round  n_round;
    t_half   n_c;
    t_half   n_d;
    logic    n_out_valid;

    logic    adv;
    logic    emit;
    logic    shift_two;
    t_half   c_rot;
    t_half   d_rot;
    t_subkey sub;

    assign adv       = !r_out_valid || !i_stall;
    assign emit      = r_busy && adv;
    // reload when idle, or in the same cycle the last round leaves
    assign o_pop     = !i_q_stat.empty && (!r_busy || (emit && r_round == LastRound));
    assign shift_two = ShiftTwoMask[r_round];
    assign c_rot     = rot_half(r_c, shift_two);
    assign d_rot     = rot_half(r_d, shift_two);
    assign sub       = pc2({c_rot, d_rot});

    always_comb begin
        n_busy      = r_busy;
        n_round     = r_round;
        n_c         = r_c;
        n_d         = r_d;
        n_out_valid = adv ? emit : r_out_valid;
        if (emit) begin
            n_c     = c_rot;
            n_d     = d_rot;
            n_round = r_round + 4'd1;
            n_busy  = (r_round != LastRound);
        end
        if (o_pop) begin
            n_c     = i_pop_data[JoinedBits-1:HalfBits];
            n_d     = i_pop_data[HalfBits-1:0];
            n_round = FirstRound;
            n_busy  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_round     <= FirstRound;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c <= n_c;
        r_d <= n_d;
        if (emit) begin
            r_out_key   <= sub;
            r_out_round <= r_round;
            r_out_last  <= (r_round == LastRound);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_round_key    = r_out_key;
    assign o_round_number = r_out_round;
    assign o_last_key     = r_out_last;

    // inside a run the next subkey follows straight after each transfer
    a_round_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_round_number != LastRound)
        |=> (o_valid && o_round_number == $past(o_round_number) + 4'd1))
        else $error("round sequence broken");

    a_idle_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_round == FirstRound))
        else $error("idle engine with nonzero round");

    a_no_pop_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_round != LastRound) |-> !o_pop)
        else $error("reload in the middle of a run");

endmodule

### design/des_round_key_schedule.sv
// top level of the des round key schedule
// Each accepted 64-bit key yields sixteen 48-bit round keys in round order,
// tagged with the round number 0..15 and a last flag on round 15. The round
// engine makes one subkey per cycle while the output is not stalled, and a
// steady stream of keys runs with no gap between runs; when the engine is
// idle, the first subkey of a key passes the queue, the c/d registers and
// the output register. A two-entry queue holds pc-1 results, so up to two
// further keys are taken while a run is in progress or while the output is
// stalled. Parity bits are ignored; every key value is processed alike.
module des_round_key_schedule (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  dks_pkg::t_key          i_key_value,
    output logic                   o_stall,
    output logic                   o_valid,
    input  logic                   i_stall,
    output dks_pkg::t_subkey       o_round_key,
    output dks_pkg::t_round        o_round_number,
    output logic                   o_last_key
);
    import dks_pkg::*;

    t_q_stat q_stat;
    logic    push;
    t_joined push_data;
    logic    pop;
    t_joined pop_data;

    dks_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_key_value (i_key_value),
        .o_stall     (o_stall),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_push_data (push_data)
    );

    dks_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_q_stat    (q_stat)
    );

    dks_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_stat       (q_stat),
        .i_pop_data     (pop_data),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_round_key    (o_round_key),
        .o_round_number (o_round_number),
        .o_last_key     (o_last_key)
    );

endmodule
